// File: hdl/rcfd_pkg.sv
// Shared types, constants and the CRC-8 step for the packed RC channel frame decoder.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none
package rcfd_pkg;

   // frame geometry
   localparam int MAX_FRAME_BYTES = 64;
   localparam int PAYLOAD_DEPTH   = 22;
   localparam int PAYLOAD_BITS    = PAYLOAD_DEPTH * 8;
   localparam int NUM_CHANNELS    = 16;
   localparam int CH_BITS         = 11;
   localparam int PULSE_BITS      = 12;
   localparam int POS_BITS        = 6;

   localparam logic [7:0] MIN_LENGTH = 8'd2;
   localparam logic [7:0] MAX_LENGTH = 8'(MAX_FRAME_BYTES - 2);

   // CRC-8, polynomial 0xD5, MSB first
   localparam logic [7:0] CRC_POLY = 8'hD5;

   // pulse width: offset plus value scaled by 0.6247712 in unsigned Q0.16
   localparam logic [15:0]           PULSE_SCALE  = 16'd40945;
   localparam logic [PULSE_BITS-1:0] PULSE_OFFSET = 12'd881;

   // register indexes
   localparam logic CSR_OWN_ADDRESS = 1'b0;
   localparam logic CSR_FRAME_TYPE  = 1'b1;

   // reset values of the registers
   localparam logic [7:0] OWN_ADDRESS_RESET = 8'd200;
   localparam logic [7:0] FRAME_TYPE_RESET  = 8'd22;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CRC_BAD   = 3'd1;
   localparam logic [2:0] ST_ADDR_BAD  = 3'd2;
   localparam logic [2:0] ST_OTHER_TYP = 3'd3;
   localparam logic [2:0] ST_BAD_LEN   = 3'd4;

   // one finished frame handed from the front to the back
   typedef struct packed {
      logic [2:0]              status;
      logic [PAYLOAD_BITS-1:0] payload;
   } job_type;

   // push from the front and full state of the job queue
   typedef struct packed {
      logic push;
      logic full;
   } qctl_type;

   // advance the CRC by one byte
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
         else      c = {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: hdl/rcfd_front.sv
// Front end: frame parser, running CRC, payload store and frame checks.
// Uses rcfd_pkg; hands one job per finished frame to rcfd_queue.
`default_nettype none
module rcfd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 byte_accept,
   input  wire logic [7:0]           byte_value,
   input  wire logic                 frame_start,
   input  wire logic                 csr_we,
   input  wire logic                 csr_index,
   input  wire logic [7:0]           csr_wdata,
   output rcfd_pkg::job_type         job,
   output logic                      job_push
);

   logic                           in_frame_ff, in_frame_in;
   logic [rcfd_pkg::POS_BITS-1:0]  pos_ff, pos_in;
   logic [7:0]                     addr_ff, addr_in;
   logic [7:0]                     len_ff, len_in;
   logic [7:0]                     type_ff, type_in;
   logic [7:0]                     crc_ff, crc_in;
   logic [7:0]                     own_addr_ff, own_addr_in;
   logic [7:0]                     frame_type_ff, frame_type_in;
   logic [7:0]                     store_ff [rcfd_pkg::PAYLOAD_DEPTH];
   logic [7:0]                     store_in [rcfd_pkg::PAYLOAD_DEPTH];
   logic [rcfd_pkg::POS_BITS-1:0]  pay_idx;
   logic                           pay_write;
   logic                           at_crc;
   logic [2:0]                     status;

   assign pay_idx = pos_ff - rcfd_pkg::POS_BITS'(3);
   assign at_crc  = ({1'b0, pos_ff} == 7'(len_ff) + 7'd1);

   // parse one byte
   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      addr_in     = addr_ff;
      len_in      = len_ff;
      type_in     = type_ff;
      crc_in      = crc_ff;
      pay_write   = 1'b0;
      job_push    = 1'b0;
      status      = rcfd_pkg::ST_OK;
      if (byte_accept) begin
         if (frame_start) begin
            in_frame_in = 1'b1;
            pos_in      = rcfd_pkg::POS_BITS'(1);
            addr_in     = byte_value;
            len_in      = 8'd0;
            type_in     = 8'd0;
            crc_in      = 8'd0;
         end else if (in_frame_ff) begin
            if (pos_ff == rcfd_pkg::POS_BITS'(1)) begin
               len_in = byte_value;
               if (byte_value < rcfd_pkg::MIN_LENGTH || byte_value > rcfd_pkg::MAX_LENGTH) begin
                  in_frame_in = 1'b0;
                  pos_in      = '0;
                  job_push    = 1'b1;
                  status      = rcfd_pkg::ST_BAD_LEN;
               end else begin
                  pos_in = rcfd_pkg::POS_BITS'(2);
               end
            end else if (pos_ff == rcfd_pkg::POS_BITS'(2)) begin
               type_in = byte_value;
               crc_in  = rcfd_pkg::crc8_step(crc_ff, byte_value);
               pos_in  = rcfd_pkg::POS_BITS'(3);
            end else if (at_crc) begin
               in_frame_in = 1'b0;
               pos_in      = '0;
               job_push    = 1'b1;
               // CRC first, then address, then type
               priority if (byte_value != crc_ff)        status = rcfd_pkg::ST_CRC_BAD;
               else if (addr_ff != own_addr_ff)          status = rcfd_pkg::ST_ADDR_BAD;
               else if (type_ff != frame_type_ff)        status = rcfd_pkg::ST_OTHER_TYP;
               else                                      status = rcfd_pkg::ST_OK;
            end else begin
               pay_write = 1'b1;
               crc_in    = rcfd_pkg::crc8_step(crc_ff, byte_value);
               pos_in    = pos_ff + rcfd_pkg::POS_BITS'(1);
            end
         end
      end
   end

   // clear the store at frame start, write payload bytes at their place
   always_comb begin
      for (int i = 0; i < rcfd_pkg::PAYLOAD_DEPTH; i++) begin
         store_in[i] = store_ff[i];
         if (byte_accept && frame_start)
            store_in[i] = 8'd0;
         else if (pay_write && pay_idx == rcfd_pkg::POS_BITS'(i))
            store_in[i] = byte_value;
      end
   end

   // register writes
   always_comb begin
      own_addr_in   = own_addr_ff;
      frame_type_in = frame_type_ff;
      if (csr_we) begin
         unique case (csr_index)
            rcfd_pkg::CSR_OWN_ADDRESS: own_addr_in   = csr_wdata;
            rcfd_pkg::CSR_FRAME_TYPE:  frame_type_in = csr_wdata;
            default:                   own_addr_in   = own_addr_ff;
         endcase
      end
   end

   // build the job
   always_comb begin
      job.status = status;
      for (int i = 0; i < rcfd_pkg::PAYLOAD_DEPTH; i++)
         job.payload[i*8 +: 8] = store_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         pos_ff        <= '0;
         addr_ff       <= 8'd0;
         len_ff        <= 8'd0;
         type_ff       <= 8'd0;
         crc_ff        <= 8'd0;
         own_addr_ff   <= rcfd_pkg::OWN_ADDRESS_RESET;
         frame_type_ff <= rcfd_pkg::FRAME_TYPE_RESET;
      end else begin
         in_frame_ff   <= in_frame_in;
         pos_ff        <= pos_in;
         addr_ff       <= addr_in;
         len_ff        <= len_in;
         type_ff       <= type_in;
         crc_ff        <= crc_in;
         own_addr_ff   <= own_addr_in;
         frame_type_ff <= frame_type_in;
      end
   end

   // payload store holds data only
   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule
`default_nettype wire

// File: hdl/rcfd_queue.sv
// Two-entry job queue between the frame parser and the channel unpacker.
// Uses rcfd_pkg for the job type.
`default_nettype none
module rcfd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  rcfd_pkg::job_type       push_job,
   input  wire logic               pop,
   output rcfd_pkg::job_type       head_job,
   output logic                    empty,
   output logic                    full
);

   rcfd_pkg::job_type mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign head_job = mem_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = ~wr_ptr_ff;
      if (pop)  rd_ptr_in = ~rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

// File: hdl/rcfd_back.sv
// Back end: unpacks channels of a job one per cycle while the output is not stalled,
// scales the pulse width and holds the result in an output register. Uses rcfd_pkg.
`default_nettype none
module rcfd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  rcfd_pkg::job_type                  head_job,
   input  wire logic                          empty,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [31:0]                        rsp_tdata,
   output logic                               rsp_tlast
);

   logic [3:0]                       chan_ff, chan_in;
   logic                             valid_ff, valid_in;
   logic [2:0]                       status_ff, status_in;
   logic [3:0]                       index_ff, index_in;
   logic [rcfd_pkg::CH_BITS-1:0]     value_ff, value_in;
   logic [rcfd_pkg::PULSE_BITS-1:0]  pulse_ff, pulse_in;
   logic                             last_ff, last_in;
   logic [rcfd_pkg::CH_BITS-1:0]     chan_sel;
   logic [26:0]                      product;
   logic                             advance, load, ok, item_last;

   assign advance   = !valid_ff || rsp_tready;
   assign load      = advance && !empty;
   assign ok        = (head_job.status == rcfd_pkg::ST_OK);
   assign item_last = !ok || (chan_ff == 4'(rcfd_pkg::NUM_CHANNELS - 1));
   assign pop       = load && item_last;

   // pick the current channel's bits
   always_comb begin
      chan_sel = '0;
      for (int i = 0; i < rcfd_pkg::NUM_CHANNELS; i++)
         if (chan_ff == 4'(i))
            chan_sel = head_job.payload[i*rcfd_pkg::CH_BITS +: rcfd_pkg::CH_BITS];
   end

   assign product = 27'(chan_sel) * 27'(rcfd_pkg::PULSE_SCALE);

   // next result and channel counter
   always_comb begin
      chan_in   = chan_ff;
      valid_in  = valid_ff;
      status_in = status_ff;
      index_in  = index_ff;
      value_in  = value_ff;
      pulse_in  = pulse_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         status_in = head_job.status;
         last_in   = item_last;
         chan_in   = item_last ? 4'd0 : chan_ff + 4'd1;
         if (ok) begin
            index_in = chan_ff;
            value_in = chan_sel;
            pulse_in = rcfd_pkg::PULSE_OFFSET + rcfd_pkg::PULSE_BITS'(product[26:16]);
         end else begin
            index_in = 4'd0;
            value_in = '0;
            pulse_in = '0;
         end
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         chan_ff  <= chan_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      index_ff  <= index_in;
      value_ff  <= value_in;
      pulse_ff  <= pulse_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, pulse_ff, value_ff, index_ff, status_ff};
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// File: hdl/rc_frame_crc_check_and_channel_unpack_core.sv
// Top level of the packed RC channel frame decoder.
// Instantiates rcfd_front, rcfd_queue and rcfd_back; uses rcfd_pkg.
//
//   channel  direction  handshake              contents
//   req      in         req_tvalid/req_tready  tdata: byte_value; tuser: frame_start
//   rsp      out        rsp_tvalid/rsp_tready  tdata: status, channel_index, channel_value,
//                                              pulse_us; tlast: last
//   csr      in         csr_we                 csr_index selects register, csr_wdata
//
// One byte is taken per cycle while req_tready is high; a frame's results leave one per cycle
// while rsp is not stalled, set by the single unpack and scale unit of the back end.
// After its frame's CRC byte, a result is registered first in the job queue, then in the output register.
// req_tready falls only while the two-entry job queue is full; rsp stalls back up into it.
// Reset is synchronous and active high; no clearing pass follows.
`default_nettype none
module rc_frame_crc_check_and_channel_unpack_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [2:0] status, [6:3] channel_index,
                                         // [17:7] channel_value, [29:18] pulse_us
   output logic             rsp_tlast,   // last
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   rcfd_pkg::job_type  front_job;
   rcfd_pkg::job_type  head_job;
   rcfd_pkg::qctl_type qctl;
   logic               q_empty;
   logic               pop;
   logic               byte_accept;

   assign req_tready  = !qctl.full;
   assign byte_accept = req_tvalid && req_tready;

   rcfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .byte_value  (req_tdata),
      .frame_start (req_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .job         (front_job),
      .job_push    (qctl.push)
   );

   rcfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (qctl.push),
      .push_job (front_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (qctl.full)
   );

   rcfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .empty      (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// File: hdl/rcfd_checker.sv
// Port-level checks for the packed RC channel frame decoder, bound to its top level.
// Uses rcfd_pkg for status codes.
`default_nettype none
module rcfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // error results are single, closing and carry no channel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != rcfd_pkg::ST_OK |->
         rsp_tlast && rsp_tdata[29:3] == 27'd0)
      else $error("error result malformed");

   // good frames close on the last channel only
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == rcfd_pkg::ST_OK |->
         rsp_tlast == (rsp_tdata[6:3] == 4'd15))
      else $error("last flag misplaced");

   // channels of a frame count up one by one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid |->
         rsp_tdata[2:0] == rcfd_pkg::ST_OK && rsp_tdata[6:3] == $past(rsp_tdata[6:3]) + 4'd1)
      else $error("channel sequence broken");

   // no result straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind rc_frame_crc_check_and_channel_unpack_core rcfd_checker u_rcfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
